[src/fla_pkg.sv]
`timescale 1ns / 1ps
package fla_pkg;
  localparam int ENTRIES = 1024;
  localparam int IW      = $clog2(ENTRIES);
  localparam int KEY_W   = 23;
  localparam int TIME_W  = 64;
  localparam int CNT_W   = 32;
  localparam int SW      = 1 + KEY_W + TIME_W;
  localparam int AW      = 1 + KEY_W + TIME_W + 2 * CNT_W;

  localparam logic [TIME_W-1:0] STALE_RESET = 64'd5000000000;
  localparam logic [31:0] MAJOR_FLAG = 32'h0000_0004;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [3:0] ST_STORED  = 4'd0;
  localparam logic [3:0] ST_ZERO    = 4'd1;
  localparam logic [3:0] ST_NOSTART = 4'd2;
  localparam logic [3:0] ST_STALE   = 4'd3;
  localparam logic [3:0] ST_ACCUM   = 4'd4;
  localparam logic [3:0] ST_CREATED = 4'd5;
  localparam logic [3:0] ST_FULL    = 4'd6;
  localparam logic [3:0] ST_QHIT    = 4'd7;
  localparam logic [3:0] ST_QMISS   = 4'd8;

  typedef struct packed {
    logic [CNT_W-1:0]  major_faults;
    logic [CNT_W-1:0]  fault_count;
    logic [TIME_W-1:0] acc_ns;
    logic [TIME_W-1:0] latency_ns;
    logic [3:0]        status;
  } res_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [SW-1:0] wdata;
    logic [IW-1:0] raddr;
  } sreq_t;

  typedef struct packed {
    logic          we;
    logic [IW-1:0] waddr;
    logic [AW-1:0] wdata;
    logic [IW-1:0] raddr;
  } areq_t;
endpackage

[src/fla_ram.sv]
`timescale 1ns / 1ps
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/fla_ctrl.sv]
`timescale 1ns / 1ps
module fla_ctrl import fla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [KEY_W-1:0]  process_id,
  input  logic [TIME_W-1:0] now_ns,
  input  logic [31:0]       fault_flags,
  input  logic [TIME_W-1:0] stale_limit,
  output sreq_t             sreq,
  input  logic [SW-1:0]     srdata,
  output areq_t             areq,
  input  logic [AW-1:0]     ardata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_LAT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state;
  logic [1:0]        cmd;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] now;
  logic              major;
  logic              phase;
  logic [IW:0]       cnt;
  logic              pend;
  logic [IW-1:0]     pidx;
  logic              hit;
  logic [IW-1:0]     hit_idx;
  logic              free_ok;
  logic [IW-1:0]     free_idx;
  logic [TIME_W-1:0] hit_time;
  logic [TIME_W-1:0] hit_total;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  hit_major;
  logic [TIME_W-1:0] lat;

  logic              m_valid;
  logic [KEY_W-1:0]  m_key;
  logic              in_acc;
  logic              scan_end;
  logic [TIME_W-1:0] new_total;
  logic [CNT_W-1:0]  new_count;
  logic [CNT_W-1:0]  new_major;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign scan_end  = (cnt == (IW+1)'(ENTRIES)) && !pend;
  assign m_valid   = phase ? ardata[AW-1] : srdata[SW-1];
  assign m_key     = phase ? ardata[AW-2 -: KEY_W] : srdata[SW-2 -: KEY_W];
  assign new_total = hit ? hit_total + lat : lat;
  assign new_count = hit ? hit_count + CNT_W'(1) : CNT_W'(1);
  assign new_major = (hit ? hit_major : '0) + CNT_W'(major);

  always_comb begin
    sreq = '0;
    areq = '0;
    sreq.raddr = cnt[IW-1:0];
    areq.raddr = cnt[IW-1:0];
    case (state)
      S_CLR: begin
        sreq.we = 1'b1;
        sreq.waddr = cnt[IW-1:0];
        areq.we = 1'b1;
        areq.waddr = cnt[IW-1:0];
      end
      S_DEC: begin
        if (!phase && cmd == CMD_START) begin
          sreq.we = hit || free_ok;
          sreq.waddr = hit ? hit_idx : free_idx;
          sreq.wdata = {1'b1, key, now};
        end else if (!phase) begin
          // An end frees its start entry whatever happens to the sample.
          sreq.we = hit;
          sreq.waddr = hit_idx;
        end else if (cmd == CMD_END) begin
          areq.we = hit || free_ok;
          areq.waddr = hit ? hit_idx : free_idx;
          areq.wdata = {1'b1, key, new_total, new_count, new_major};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          cnt <= cnt + (IW+1)'(1);
          if (cnt[IW-1:0] == IW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd     <= command;
            key     <= process_id;
            now     <= now_ns;
            major   <= |(fault_flags & MAJOR_FLAG);
            phase   <= (command == CMD_QUERY);
            cnt     <= '0;
            pend    <= 1'b0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            // The status only matters for the two requests answered at once.
            res.status       <= (command == CMD_UNUSED) ? ST_QMISS : ST_ZERO;
            res.latency_ns   <= '0;
            res.acc_ns       <= '0;
            res.fault_count  <= '0;
            res.major_faults <= '0;
            if (command == CMD_UNUSED || process_id == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt != (IW+1)'(ENTRIES)) begin
            cnt <= cnt + (IW+1)'(1);
          end
          pend <= (cnt != (IW+1)'(ENTRIES));
          pidx <= cnt[IW-1:0];
          if (pend) begin
            if (m_valid && m_key == key) begin
              hit       <= 1'b1;
              hit_idx   <= pidx;
              hit_time  <= srdata[TIME_W-1:0];
              hit_total <= ardata[AW-2-KEY_W -: TIME_W];
              hit_count <= ardata[2*CNT_W-1:CNT_W];
              hit_major <= ardata[CNT_W-1:0];
            end
            if (!m_valid && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= pidx;
            end
          end
          if (scan_end) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          state <= (!phase && cmd == CMD_END && hit) ? S_LAT : S_DONE;
          if (!phase && cmd == CMD_START) begin
            res.status <= (hit || free_ok) ? ST_STORED : ST_FULL;
          end else if (!phase) begin
            if (hit) begin
              lat <= now - hit_time;
            end else begin
              res.status <= ST_NOSTART;
            end
          end else if (cmd == CMD_END) begin
            res.latency_ns <= lat;
            if (hit || free_ok) begin
              res.status       <= hit ? ST_ACCUM : ST_CREATED;
              res.acc_ns       <= new_total;
              res.fault_count  <= new_count;
              res.major_faults <= new_major;
            end else begin
              res.status <= ST_FULL;
            end
          end else begin
            res.status <= hit ? ST_QHIT : ST_QMISS;
            if (hit) begin
              res.acc_ns       <= hit_total;
              res.fault_count  <= hit_count;
              res.major_faults <= hit_major;
            end
          end
        end
        S_LAT: begin
          if (lat > stale_limit) begin
            res.status     <= ST_STALE;
            res.latency_ns <= lat;
            state <= S_DONE;
          end else begin
            phase   <= 1'b1;
            cnt     <= '0;
            pend    <= 1'b0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!sreq.we && !areq.we))
    else $error("table written during scan");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != S_IDLE))
    else $error("request accepted but controller stayed idle");
  a_scan_starts_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == '0) |-> (!pend && !hit && !free_ok))
    else $error("scan started with stale match state");
endmodule

[src/per_id_fault_latency_accumulator.sv]
`timescale 1ns / 1ps
// Per-ID fault latency accumulator.
// Input requests arrive on s_tvalid/s_tready/s_tdata: a fault start, a fault
// end or a query, keyed by process_id. Each request yields exactly one result
// on m_tvalid/m_tready/m_tdata, in request order.
// The start table and the accumulator table each live in a single-port-read
// RAM of ENTRIES words. Every lookup is a linear sweep of one table, one word
// per cycle; an end that reaches the accumulator sweeps the start table and
// then the accumulator table. The sweep sets the throughput, and one request
// is in flight at a time.
// A result sits in an output register; the next request is taken while it
// waits, but a second result is held back until m_tready drains the first.
// After reset a clearing pass marks every entry of both tables free; s_tready
// stays low during it. The stale limit resets to 5000000000 ns; the user must
// write it through cfg_valid/cfg_data only while idle (block does not enforce).
module per_id_fault_latency_accumulator import fla_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[1:0], process_id[24:2], now_ns[88:25], fault_flags[120:89]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[3:0], latency_ns[67:4], acc_ns[131:68], fault_count[163:132],
  // major_faults[195:164]
  output logic [199:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data
);
  logic [TIME_W-1:0] stale_limit;
  sreq_t             sreq;
  areq_t             areq;
  logic [SW-1:0]     srdata;
  logic [AW-1:0]     ardata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_res;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {4'b0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        stale_limit <= cfg_data;
      end
      if (res_ready) begin
        m_tvalid <= res_valid;
        if (res_valid) begin
          out_res <= res;
        end
      end
    end
  end

  fla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .command     (s_tdata[1:0]),
    .process_id  (s_tdata[24:2]),
    .now_ns      (s_tdata[88:25]),
    .fault_flags (s_tdata[120:89]),
    .stale_limit (stale_limit),
    .sreq        (sreq),
    .srdata      (srdata),
    .areq        (areq),
    .ardata      (ardata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  fla_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_start_ram (
    .clk   (clk),
    .we    (sreq.we),
    .waddr (sreq.waddr),
    .wdata (sreq.wdata),
    .raddr (sreq.raddr),
    .rdata (srdata)
  );

  fla_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_accum_ram (
    .clk   (clk),
    .we    (areq.we),
    .waddr (areq.waddr),
    .wdata (areq.wdata),
    .raddr (areq.raddr),
    .rdata (ardata)
  );
endmodule
